// File: rtl/bwt_block_transform_assert.svh
// Assertion macros for the block transform RTL.
// Used by the top level; no other dependencies.
`ifndef BWT_BLOCK_TRANSFORM_ASSERT_SVH
`define BWT_BLOCK_TRANSFORM_ASSERT_SVH
`ifndef SYNTH
`define BWT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bwt assertion failed");
`define BWT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("bwt forbidden condition");
`else
`define BWT_ASSERT(lbl, clk, rst_n, prop)
`define BWT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/bwt_pkg.sv
// Shared constants and types for the block transform.
// No dependencies.
package bwt_pkg;
    localparam int BLOCK_SIZE = 64;
    localparam int IDX_W      = $clog2(BLOCK_SIZE);
    localparam int LEN_W      = IDX_W + 1;

    typedef logic [7:0]       sym_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic start;
        idx_t a;
        idx_t b;
        len_t n;
    } cmp_req_t;

    typedef struct packed {
        logic done;
        logic after;
    } cmp_rsp_t;
endpackage

// File: rtl/bwt_store.sv
// Block symbol memory: one write port, two registered read ports.
// Depends on bwt_pkg.
module bwt_store (
    input  logic          aclk,
    input  logic          we,
    input  bwt_pkg::idx_t wa,
    input  bwt_pkg::sym_t wd,
    input  bwt_pkg::idx_t ra,
    input  bwt_pkg::idx_t rb,
    output bwt_pkg::sym_t rd_a,
    output bwt_pkg::sym_t rd_b
);
    import bwt_pkg::*;

    sym_t mem [BLOCK_SIZE];
    sym_t rd_a_reg;
    sym_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[rb];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;
endmodule

// File: rtl/bwt_rot_cmp.sv
// Rotation comparator: walks two cyclic rotations one symbol pair at a time.
// Depends on bwt_pkg; reads symbols through the block store ports.
module bwt_rot_cmp (
    input  logic              aclk,
    input  logic              aresetn,
    input  bwt_pkg::cmp_req_t req,
    output bwt_pkg::cmp_rsp_t rsp,
    output bwt_pkg::idx_t     addr_a,
    output bwt_pkg::idx_t     addr_b,
    input  bwt_pkg::sym_t     sym_a,
    input  bwt_pkg::sym_t     sym_b
);
    import bwt_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_FETCH = 3'b010,
        C_CHECK = 3'b100
    } cstate_t;

    cstate_t state_reg, state_next;
    idx_t pa_reg, pa_next, pb_reg, pb_next;
    idx_t a_reg, a_next, b_reg, b_next;
    len_t n_reg, n_next, k_reg, k_next;
    logic done_reg, done_next, after_reg, after_next;

    always_comb begin
        state_next = state_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        after_next = after_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (req.start) begin
                    pa_next    = req.a;
                    pb_next    = req.b;
                    a_next     = req.a;
                    b_next     = req.b;
                    n_next     = req.n;
                    k_next     = '0;
                    state_next = C_FETCH;
                end
            end
            C_FETCH: begin
                state_next = C_CHECK;
            end
            C_CHECK: begin
                if (sym_a != sym_b) begin
                    done_next  = 1'b1;
                    after_next = (sym_a > sym_b);
                    state_next = C_IDLE;
                end else if (k_reg == n_reg - len_t'(1)) begin
                    // equal rotations: smaller start sorts first
                    done_next  = 1'b1;
                    after_next = (a_reg > b_reg);
                    state_next = C_IDLE;
                end else begin
                    k_next     = k_reg + len_t'(1);
                    pa_next    = ({1'b0, pa_reg} == n_reg - len_t'(1)) ? '0 : pa_reg + idx_t'(1);
                    pb_next    = ({1'b0, pb_reg} == n_reg - len_t'(1)) ? '0 : pb_reg + idx_t'(1);
                    state_next = C_FETCH;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        after_reg <= after_next;
    end

    assign addr_a    = pa_reg;
    assign addr_b    = pb_reg;
    assign rsp.done  = done_reg;
    assign rsp.after = after_reg;
endmodule

// File: rtl/bwt_block_transform.sv
// Block transform top: loads up to 64 symbols at one per cycle, then sorts
// rotations by insertion with a shared rotation comparator (it fetches, then
// checks, each symbol pair), so sorting costs O(n^2) compares of up to n
// symbols each. Each result passes S_OUT_RD and S_OUT_ST, then waits in
// S_OUT_HOLD for m_ready. Reset (aresetn, synchronous) empties the block.
module bwt_block_transform (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bwt_pkg::sym_t s_symbol,
    input  logic          s_block_end,
    output logic          m_valid,
    input  logic          m_ready,
    output bwt_pkg::sym_t m_out_symbol,
    output bwt_pkg::idx_t m_primary_index,
    output logic          m_out_last
);
    import bwt_pkg::*;
    `include "bwt_block_transform_assert.svh"

    typedef enum logic [7:0] {
        S_LOAD     = 8'b00000001,
        S_ORD_RD   = 8'b00000010,
        S_CMP_GO   = 8'b00000100,
        S_CMP_WAIT = 8'b00001000,
        S_PLACE    = 8'b00010000,
        S_OUT_RD   = 8'b00100000,
        S_OUT_ST   = 8'b01000000,
        S_OUT_HOLD = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    len_t len_reg, len_next, n_reg, n_next;
    len_t i_reg, i_next, j_reg, j_next;
    idx_t a_reg, a_next, prim_reg, prim_next;
    logic m_valid_reg, m_valid_next, last_reg, last_next, sym_sel_reg, sym_sel_next;
    sym_t out_sym_reg;

    idx_t ord_mem [BLOCK_SIZE];
    idx_t ord_rd_reg;
    logic ord_we;
    idx_t ord_wa, ord_wd, ord_ra;

    logic st_we;
    idx_t st_ra, cmp_pa, cmp_pb, prev_idx;
    sym_t st_rd_a, st_rd_b;
    cmp_req_t cmp_req;
    cmp_rsp_t cmp_rsp;
    logic closing;

    bwt_store u_store (
        .aclk (aclk),
        .we   (st_we),
        .wa   (len_reg[IDX_W-1:0]),
        .wd   (s_symbol),
        .ra   (st_ra),
        .rb   (cmp_pb),
        .rd_a (st_rd_a),
        .rd_b (st_rd_b)
    );

    bwt_rot_cmp u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cmp_req),
        .rsp     (cmp_rsp),
        .addr_a  (cmp_pa),
        .addr_b  (cmp_pb),
        .sym_a   (st_rd_a),
        .sym_b   (st_rd_b)
    );

    assign s_ready = (state_reg == S_LOAD);
    assign st_we   = s_valid && s_ready;
    assign closing = s_block_end || (len_reg == len_t'(BLOCK_SIZE - 1));
    assign prev_idx = (ord_rd_reg == '0) ? idx_t'(n_reg - len_t'(1)) : ord_rd_reg - idx_t'(1);
    assign st_ra   = (state_reg == S_OUT_ST) ? prev_idx : cmp_pa;
    assign ord_ra  = (state_reg == S_OUT_RD) ? i_reg[IDX_W-1:0] : idx_t'(j_reg - len_t'(1));

    assign cmp_req.start = (state_reg == S_CMP_GO);
    assign cmp_req.a     = ord_rd_reg;
    assign cmp_req.b     = i_reg[IDX_W-1:0];
    assign cmp_req.n     = n_reg;

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        a_next       = a_reg;
        prim_next    = prim_reg;
        m_valid_next = m_valid_reg;
        last_next    = last_reg;
        sym_sel_next = 1'b0;
        ord_we       = 1'b0;
        ord_wa       = '0;
        ord_wd       = '0;
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    len_next = len_reg + len_t'(1);
                    if (closing) begin
                        len_next  = '0;
                        n_next    = len_reg + len_t'(1);
                        prim_next = '0;
                        ord_we    = 1'b1;
                        i_next    = (len_reg == '0) ? '0 : len_t'(1);
                        j_next    = len_t'(1);
                        state_next = (len_reg == '0) ? S_OUT_RD : S_ORD_RD;
                    end
                end
            end
            S_ORD_RD: state_next = S_CMP_GO;
            S_CMP_GO: begin
                a_next     = ord_rd_reg;
                state_next = S_CMP_WAIT;
            end
            S_CMP_WAIT: begin
                if (cmp_rsp.done) begin
                    ord_we = 1'b1;
                    ord_wa = j_reg[IDX_W-1:0];
                    if (cmp_rsp.after) begin
                        // shift the larger rotation up one slot
                        ord_wd = a_reg;
                        if (a_reg == '0) begin
                            prim_next = j_reg[IDX_W-1:0];
                        end
                        j_next     = j_reg - len_t'(1);
                        state_next = (j_reg == len_t'(1)) ? S_PLACE : S_ORD_RD;
                    end else begin
                        ord_wd = i_reg[IDX_W-1:0];
                        i_next = i_reg + len_t'(1);
                        j_next = i_reg + len_t'(1);
                        if (i_reg + len_t'(1) == n_reg) begin
                            i_next     = '0;
                            state_next = S_OUT_RD;
                        end else begin
                            state_next = S_ORD_RD;
                        end
                    end
                end
            end
            S_PLACE: begin
                ord_we = 1'b1;
                ord_wa = '0;
                ord_wd = i_reg[IDX_W-1:0];
                i_next = i_reg + len_t'(1);
                j_next = i_reg + len_t'(1);
                if (i_reg + len_t'(1) == n_reg) begin
                    i_next     = '0;
                    state_next = S_OUT_RD;
                end else begin
                    state_next = S_ORD_RD;
                end
            end
            S_OUT_RD: state_next = S_OUT_ST;
            S_OUT_ST: begin
                sym_sel_next = 1'b1;
                m_valid_next = 1'b1;
                last_next    = (i_reg + len_t'(1) == n_reg);
                state_next   = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (m_valid_reg && m_ready) begin
                    m_valid_next = 1'b0;
                    i_next       = i_reg + len_t'(1);
                    state_next   = last_reg ? S_LOAD : S_OUT_RD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            ord_mem[ord_wa] <= ord_wd;
        end
        ord_rd_reg <= ord_mem[ord_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
            sym_sel_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
            sym_sel_reg <= sym_sel_next;
        end
        n_reg    <= n_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        a_reg    <= a_next;
        prim_reg <= prim_next;
        last_reg <= last_next;
        // capture the store read the cycle after the address was issued
        if (sym_sel_reg) begin
            out_sym_reg <= st_rd_a;
        end
    end

    // store data lands in the cycle after S_OUT_ST; hold it while presenting
    assign m_out_symbol    = sym_sel_reg ? st_rd_a : out_sym_reg;
    assign m_primary_index = prim_reg;
    assign m_out_last      = last_reg;
    assign m_valid         = m_valid_reg;

    `BWT_NEVER(a_no_overlap, aclk, aresetn, s_ready && m_valid)
    `BWT_ASSERT(a_last_returns, aclk, aresetn, m_valid && m_ready && m_out_last |=> s_ready)
    `BWT_ASSERT(a_len_bound, aclk, aresetn, len_reg < len_t'(BLOCK_SIZE))
    `BWT_ASSERT(a_cmp_only_wait, aclk, aresetn, cmp_rsp.done |-> state_reg == S_CMP_WAIT)
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for bwt_block_transform: drives symbol blocks, predicts
// the sorted-rotation output of each block and checks every result transfer.
// Depends on bwt_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_top;
    import bwt_pkg::*;

    typedef struct {
        sym_t sym;
        logic blk_end;
        bit   drain;
    } sym_item_t;

    typedef struct {
        sym_t sym;
        idx_t prim;
        logic last;
    } bwt_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sym_t s_symbol = '0;
    logic s_block_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    sym_t m_out_symbol;
    idx_t m_primary_index;
    logic m_out_last;

    sym_item_t pend_q[$];
    bwt_out_t  bwt_exp_q[$];
    sym_t      blk_mem[BLOCK_SIZE];
    int        blk_n = 0;
    int        err_cnt = 0;
    int        cyc = 0;
    int        send_gap = 0;
    int        recv_hold = 0;
    int        rx_cnt = 0;
    bit        no_idle = 0;

    bwt_block_transform u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_symbol(s_symbol), .s_block_end(s_block_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_symbol(m_out_symbol), .m_primary_index(m_primary_index),
        .m_out_last(m_out_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // True when the rotation starting at a sorts after the one at b.
    function automatic bit rot_later(int a, int b, int n);
        int pa;
        int pb;
        pa = a;
        pb = b;
        for (int k = 0; k < n; k++) begin
            if (blk_mem[pa] != blk_mem[pb]) return blk_mem[pa] > blk_mem[pb];
            pa = (pa + 1 == n) ? 0 : pa + 1;
            pb = (pb + 1 == n) ? 0 : pb + 1;
        end
        return a > b;
    endfunction

    task automatic transform_block();
        int ord[BLOCK_SIZE];
        int v;
        int j;
        int prim;
        int st;
        bwt_out_t r;
        for (int i = 0; i < blk_n; i++) ord[i] = i;
        for (int i = 1; i < blk_n; i++) begin
            v = ord[i];
            j = i;
            while (j > 0 && rot_later(ord[j-1], v, blk_n)) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = v;
        end
        prim = 0;
        for (int i = 0; i < blk_n; i++) if (ord[i] == 0) prim = i;
        for (int i = 0; i < blk_n; i++) begin
            st = ord[i];
            r.sym = blk_mem[(st == 0) ? blk_n - 1 : st - 1];
            r.prim = idx_t'(prim);
            r.last = (i + 1 == blk_n);
            bwt_exp_q.push_back(r);
        end
        blk_n = 0;
    endtask

    task automatic load_symbol(sym_t sym, logic blk_end);
        blk_mem[blk_n] = sym;
        blk_n++;
        if (blk_end || blk_n == BLOCK_SIZE) transform_block();
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, rx_cnt);
        err_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle) return 0;
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: offer pending symbols, predict on each accepted transfer.
    always @(posedge aclk) begin
        sym_item_t it;
        bit acc;
        bit vld;
        vld = s_valid;
        if (aresetn) begin
            acc = s_valid && s_ready;
            if (acc) load_symbol(s_symbol, s_block_end);
            if (!s_valid || acc) begin
                vld = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_q.size() > 0 &&
                             (!pend_q[0].drain || bwt_exp_q.size() == 0)) begin
                    it = pend_q.pop_front();
                    s_symbol <= it.sym;
                    s_block_end <= it.blk_end;
                    vld = 1'b1;
                    send_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
                end
            end
        end
        s_valid <= vld;
    end

    // Monitor: random backpressure, one long hold-off, field checks.
    always @(posedge aclk) begin
        bwt_out_t w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (bwt_exp_q.size() == 0) begin
                    $display("unexpected result transfer %0d", rx_cnt);
                    err_cnt++;
                end else begin
                    w = bwt_exp_q.pop_front();
                    if (m_out_symbol !== w.sym)
                        report_mismatch("out_symbol", m_out_symbol, w.sym);
                    if (m_primary_index !== w.prim)
                        report_mismatch("primary_index", m_primary_index, w.prim);
                    if (m_out_last !== w.last)
                        report_mismatch("out_last", m_out_last, w.last);
                end
                rx_cnt++;
                if (rx_cnt == 150) recv_hold = 3000;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 19) < 14) ||
                           ($urandom_range(0, 29) == 0 && 1'b0);
                if ($urandom_range(0, 99) == 0) recv_hold = $urandom_range(20, 60);
            end
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc > 10000000) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic queue_block(int len, int mode, logic close, bit drain);
        sym_item_t it;
        sym_t fill;
        fill = sym_t'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: it.sym = sym_t'($urandom_range(0, 255));
                1: it.sym = sym_t'($urandom_range(0, 3)) + fill;
                default: it.sym = fill;
            endcase
            it.blk_end = (i == len - 1) ? close : 1'b0;
            it.drain = drain && (i == 0);
            pend_q.push_back(it);
        end
    endtask

    task automatic queue_fixed(sym_t a, logic e);
        sym_item_t it;
        it.sym = a;
        it.blk_end = e;
        it.drain = 0;
        pend_q.push_back(it);
    endtask

    initial begin
        int items;
        int len;
        int wait_cyc;
        // single-symbol blocks at both extremes, then a two-symbol block of both
        queue_fixed(8'h00, 1'b1);
        queue_fixed(8'hFF, 1'b1);
        queue_fixed(8'hFF, 1'b0);
        queue_fixed(8'h00, 1'b1);
        // equal rotations: ties resolve by start position
        queue_fixed(8'hA5, 1'b0);
        queue_fixed(8'hA5, 1'b1);
        queue_fixed(8'h01, 1'b0);
        queue_fixed(8'h02, 1'b0);
        queue_fixed(8'h01, 1'b0);
        queue_fixed(8'h02, 1'b1);
        // hold this block until every earlier result has drained
        queue_block(8, 2, 1'b1, 1);
        // full block closes on size even with block_end low
        queue_block(BLOCK_SIZE, 0, 1'b0, 0);
        items = 0;
        while (items < 350) begin
            case ($urandom_range(0, 24))
                0: len = BLOCK_SIZE;
                1, 2: len = 1;
                default: len = $urandom_range(2, 10);
            endcase
            queue_block(len, (len == BLOCK_SIZE) ? $urandom_range(0, 1) : $urandom_range(0, 2),
                        (len == BLOCK_SIZE) ? logic'($urandom_range(0, 1)) : 1'b1,
                        (items > 200 && items < 215));
            items += len;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        while (pend_q.size() > 0 || s_valid) @(posedge aclk);
        while (bwt_exp_q.size() > 0) @(posedge aclk);
        wait_cyc = 0;
        while (wait_cyc < 500) begin
            @(posedge aclk);
            wait_cyc++;
        end
        if (err_cnt == 0 && bwt_exp_q.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/bwt_pkg.sv
rtl/bwt_store.sv
rtl/bwt_rot_cmp.sv
rtl/bwt_block_transform.sv
tb/tb_top.sv
